>>> sv/assert_macros.svh
// Assertion helpers; clock is "clock", reset is "reset" (active high).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> cons) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> cons) \
      else $error("assertion failed");
`else
`define ASSERT_SAME(label, ante, cons)
`define ASSERT_NEXT(label, ante, cons)
`endif

`endif

>>> sv/hlcr_pkg.sv
package hlcr_pkg;

   localparam int COORD_W = 24;
   localparam int TRIG_W  = 16;
   localparam int PITCH_W = 16;
   localparam int INDEX_W = 10;
   localparam int CSR_IDX_W = 3;

   // grid offsets in Q.8: +7.0 on x, -1.0 on y
   localparam int X_OFFSET = 1792;
   localparam int Y_OFFSET = 256;

   // rounding bias for Q.22 -> Q.8
   localparam int ROUND_HALF = 8192;
   localparam int ROUND_SHIFT = 14;

   localparam int COS_RESET = 16384;

   localparam logic [CSR_IDX_W-1:0] REG_ORIGIN_X   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ORIGIN_Y   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_LENS_PITCH = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_ROW_PITCH  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_CENTER_X   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_CENTER_Y   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_COS_ANGLE  = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_SIN_ANGLE  = 3'd7;

   localparam int WIDE_W = 36;

   typedef logic signed [COORD_W-1:0] coord_type;

   function automatic coord_type sat_coord(input logic signed [WIDE_W-1:0] v);
      logic signed [WIDE_W-1:0] hi;
      logic signed [WIDE_W-1:0] lo;
      hi = WIDE_W'(signed'(24'sh7FFFFF));
      lo = WIDE_W'(signed'(24'sh800000));
      if (v > hi) begin
         return 24'sh7FFFFF;
      end else if (v < lo) begin
         return 24'sh800000;
      end else begin
         return v[COORD_W-1:0];
      end
   endfunction

endpackage

>>> sv/hex_lens_center_rotate.sv
// Hexagonal lens grid point generator with rotation. Give a lens index on
// req_lens_row / req_lens_col with start; busy stays low, so one index can be
// issued every clock. For each accepted index rsp_strobe is high for one
// cycle with the grid center (rsp_grid_x/y) and the center rotated about
// (center_x, center_y) (rsp_turned_x/y), all Q16.8 and saturated. The
// result passes through six register stages: index multiply, grid sum,
// center offset and grid saturate, rotation multiply, rotation sum and round,
// final add and saturate. The receiver cannot stall, so results must be taken when shown.
// Registers are written through csr_we/csr_index/csr_wdata and should only
// change while no transaction is in flight.
`include "assert_macros.svh"

module hex_lens_center_rotate (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     start,
   output logic                                     busy,
   input  logic [hlcr_pkg::INDEX_W-1:0]             req_lens_row,
   input  logic [hlcr_pkg::INDEX_W-1:0]             req_lens_col,
   output logic                                     rsp_strobe,
   output logic signed [hlcr_pkg::COORD_W-1:0]      rsp_grid_x,
   output logic signed [hlcr_pkg::COORD_W-1:0]      rsp_grid_y,
   output logic signed [hlcr_pkg::COORD_W-1:0]      rsp_turned_x,
   output logic signed [hlcr_pkg::COORD_W-1:0]      rsp_turned_y,
   input  logic                                     csr_we,
   input  logic [hlcr_pkg::CSR_IDX_W-1:0]           csr_index,
   input  logic [hlcr_pkg::COORD_W-1:0]             csr_wdata
);

   localparam int LATENCY = 6;

   // ---------------- configuration ----------------
   logic signed [hlcr_pkg::COORD_W-1:0] origin_x_ff, origin_y_ff;
   logic signed [hlcr_pkg::COORD_W-1:0] center_x_ff, center_y_ff;
   logic [hlcr_pkg::PITCH_W-1:0]        lens_pitch_ff, row_pitch_ff;
   logic signed [hlcr_pkg::TRIG_W-1:0]  cos_angle_ff, sin_angle_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff   <= '0;
         origin_y_ff   <= '0;
         lens_pitch_ff <= '0;
         row_pitch_ff  <= '0;
         center_x_ff   <= '0;
         center_y_ff   <= '0;
         cos_angle_ff  <= hlcr_pkg::TRIG_W'(hlcr_pkg::COS_RESET);
         sin_angle_ff  <= '0;
      end else if (csr_we) begin
         case (csr_index)
            hlcr_pkg::REG_ORIGIN_X:   origin_x_ff   <= csr_wdata;
            hlcr_pkg::REG_ORIGIN_Y:   origin_y_ff   <= csr_wdata;
            hlcr_pkg::REG_LENS_PITCH: lens_pitch_ff <= csr_wdata[hlcr_pkg::PITCH_W-1:0];
            hlcr_pkg::REG_ROW_PITCH:  row_pitch_ff  <= csr_wdata[hlcr_pkg::PITCH_W-1:0];
            hlcr_pkg::REG_CENTER_X:   center_x_ff   <= csr_wdata;
            hlcr_pkg::REG_CENTER_Y:   center_y_ff   <= csr_wdata;
            hlcr_pkg::REG_COS_ANGLE:  cos_angle_ff  <= csr_wdata[hlcr_pkg::TRIG_W-1:0];
            hlcr_pkg::REG_SIN_ANGLE:  sin_angle_ff  <= csr_wdata[hlcr_pkg::TRIG_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------- valid chain ----------------
   logic                accept;
   logic [LATENCY-1:0]  valid_ff, valid_in;

   assign busy     = 1'b0;
   assign accept   = start & ~busy;
   assign valid_in = {valid_ff[LATENCY-2:0], accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // ---------------- stage 1: index products ----------------
   logic [hlcr_pkg::INDEX_W:0]                      col_inc;
   logic [hlcr_pkg::INDEX_W+hlcr_pkg::PITCH_W:0]    col_prod_in, col_prod_ff;
   logic [hlcr_pkg::INDEX_W+hlcr_pkg::PITCH_W-1:0]  row_prod_in, row_prod_ff;
   logic                                            even_row_ff;

   assign col_inc     = {1'b0, req_lens_col} + 11'd1;
   assign col_prod_in = col_inc * lens_pitch_ff;
   assign row_prod_in = req_lens_row * row_pitch_ff;

   always_ff @(posedge clock) begin
      col_prod_ff <= col_prod_in;
      row_prod_ff <= row_prod_in;
      even_row_ff <= ~req_lens_row[0];
   end

   // ---------------- stage 2: grid center ----------------
   logic signed [29:0] gx_in, gx_ff;
   logic signed [28:0] gy_in, gy_ff;
   logic [hlcr_pkg::PITCH_W-2:0] half_pitch;

   assign half_pitch = even_row_ff ? lens_pitch_ff[hlcr_pkg::PITCH_W-1:1] : '0;
   assign gx_in = 30'(origin_x_ff) + 30'($signed({1'b0, col_prod_ff}))
                + 30'(hlcr_pkg::X_OFFSET) + 30'($signed({1'b0, half_pitch}));
   assign gy_in = 29'(origin_y_ff) + 29'($signed({1'b0, row_prod_ff}))
                - 29'(hlcr_pkg::Y_OFFSET);

   always_ff @(posedge clock) begin
      gx_ff <= gx_in;
      gy_ff <= gy_in;
   end

   // ---------------- stage 3: offset from center, grid saturate ----------------
   logic signed [30:0] dx_in, dx_ff;
   logic signed [29:0] dy_in, dy_ff;
   hlcr_pkg::coord_type grid_x_s3_ff, grid_y_s3_ff;

   assign dx_in = 31'(gx_ff) - 31'(center_x_ff);
   assign dy_in = 30'(gy_ff) - 30'(center_y_ff);

   always_ff @(posedge clock) begin
      dx_ff        <= dx_in;
      dy_ff        <= dy_in;
      grid_x_s3_ff <= hlcr_pkg::sat_coord(hlcr_pkg::WIDE_W'(gx_ff));
      grid_y_s3_ff <= hlcr_pkg::sat_coord(hlcr_pkg::WIDE_W'(gy_ff));
   end

   // ---------------- stage 4: rotation products ----------------
   logic signed [46:0] p_xc_in, p_xs_in, p_xc_ff, p_xs_ff;
   logic signed [45:0] p_yc_in, p_ys_in, p_yc_ff, p_ys_ff;
   hlcr_pkg::coord_type grid_x_s4_ff, grid_y_s4_ff;

   assign p_xc_in = dx_ff * cos_angle_ff;
   assign p_xs_in = dx_ff * sin_angle_ff;
   assign p_yc_in = dy_ff * cos_angle_ff;
   assign p_ys_in = dy_ff * sin_angle_ff;

   always_ff @(posedge clock) begin
      p_xc_ff      <= p_xc_in;
      p_xs_ff      <= p_xs_in;
      p_yc_ff      <= p_yc_in;
      p_ys_ff      <= p_ys_in;
      grid_x_s4_ff <= grid_x_s3_ff;
      grid_y_s4_ff <= grid_y_s3_ff;
   end

   // ---------------- stage 5: sum and round half up ----------------
   logic signed [48:0] sum_x, sum_y;
   logic signed [34:0] rx_in, ry_in, rx_ff, ry_ff;
   hlcr_pkg::coord_type grid_x_s5_ff, grid_y_s5_ff;

   assign sum_x = 49'(p_xc_ff) - 49'(p_ys_ff) + 49'(hlcr_pkg::ROUND_HALF);
   assign sum_y = 49'(p_xs_ff) + 49'(p_yc_ff) + 49'(hlcr_pkg::ROUND_HALF);
   assign rx_in = 35'(sum_x >>> hlcr_pkg::ROUND_SHIFT);
   assign ry_in = 35'(sum_y >>> hlcr_pkg::ROUND_SHIFT);

   always_ff @(posedge clock) begin
      rx_ff        <= rx_in;
      ry_ff        <= ry_in;
      grid_x_s5_ff <= grid_x_s4_ff;
      grid_y_s5_ff <= grid_y_s4_ff;
   end

   // ---------------- stage 6: add center, saturate ----------------
   logic signed [hlcr_pkg::WIDE_W-1:0] tx, ty;
   hlcr_pkg::coord_type turned_x_ff, turned_y_ff, grid_x_ff, grid_y_ff;

   assign tx = hlcr_pkg::WIDE_W'(rx_ff) + hlcr_pkg::WIDE_W'(center_x_ff);
   assign ty = hlcr_pkg::WIDE_W'(ry_ff) + hlcr_pkg::WIDE_W'(center_y_ff);

   always_ff @(posedge clock) begin
      turned_x_ff <= hlcr_pkg::sat_coord(tx);
      turned_y_ff <= hlcr_pkg::sat_coord(ty);
      grid_x_ff   <= grid_x_s5_ff;
      grid_y_ff   <= grid_y_s5_ff;
   end

   assign rsp_strobe   = valid_ff[LATENCY-1];
   assign rsp_grid_x   = grid_x_ff;
   assign rsp_grid_y   = grid_y_ff;
   assign rsp_turned_x = turned_x_ff;
   assign rsp_turned_y = turned_y_ff;

   // ---------------- assertions ----------------
   `ASSERT_SAME(a_accept_to_strobe, accept, ##6 rsp_strobe)
   `ASSERT_SAME(a_strobe_from_accept, rsp_strobe, $past(accept, LATENCY))
   `ASSERT_NEXT(a_empty_no_strobe, valid_ff[LATENCY-2:0] == '0, !rsp_strobe)

endmodule

>>> verif/hlcr_checker.sv
`timescale 1ns / 1ps

module hlcr_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic                                busy,
   input  logic [hlcr_pkg::INDEX_W-1:0]        req_lens_row,
   input  logic [hlcr_pkg::INDEX_W-1:0]        req_lens_col,
   input  logic                                rsp_strobe,
   input  logic signed [hlcr_pkg::COORD_W-1:0] rsp_grid_x,
   input  logic signed [hlcr_pkg::COORD_W-1:0] rsp_grid_y,
   input  logic signed [hlcr_pkg::COORD_W-1:0] rsp_turned_x,
   input  logic signed [hlcr_pkg::COORD_W-1:0] rsp_turned_y,
   input  logic                                csr_we,
   input  logic [hlcr_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [hlcr_pkg::COORD_W-1:0]        csr_wdata,
   output int                                  mismatch_count,
   output int                                  lenses_pending,
   output int                                  centers_checked
);

   localparam longint COORD_HI = 64'sd8388607;
   localparam longint COORD_LO = -64'sd8388608;

   typedef struct packed {
      hlcr_pkg::coord_type grid_x;
      hlcr_pkg::coord_type grid_y;
      hlcr_pkg::coord_type turned_x;
      hlcr_pkg::coord_type turned_y;
   } lens_center_type;

   lens_center_type centers_due[$];

   // shadow of the register file, kept at full precision
   longint org_x, org_y, pitch, rpitch, ctr_x, ctr_y, cos_q, sin_q;

   initial begin
      mismatch_count = 0;
      lenses_pending = 0;
      centers_checked = 0;
   end

   function automatic hlcr_pkg::coord_type clamp_coord(input longint v);
      if (v > COORD_HI) begin
         return COORD_HI[hlcr_pkg::COORD_W-1:0];
      end else if (v < COORD_LO) begin
         return COORD_LO[hlcr_pkg::COORD_W-1:0];
      end
      return v[hlcr_pkg::COORD_W-1:0];
   endfunction

   function automatic lens_center_type place_lens(
         input logic [hlcr_pkg::INDEX_W-1:0] row,
         input logic [hlcr_pkg::INDEX_W-1:0] col);
      longint gx, gy, dx, dy, tx, ty;
      lens_center_type c;
      gx = org_x + (longint'(col) + 1) * pitch + hlcr_pkg::X_OFFSET;
      // even rows sit half a pitch to the right; odd pitch loses its low bit
      if (!row[0]) begin
         gx = gx + (pitch >>> 1);
      end
      gy = org_y + longint'(row) * rpitch - hlcr_pkg::Y_OFFSET;
      // rotate the unsaturated center, Q.22 products rounded half up to Q.8
      dx = gx - ctr_x;
      dy = gy - ctr_y;
      tx = ((dx * cos_q - dy * sin_q + hlcr_pkg::ROUND_HALF) >>> hlcr_pkg::ROUND_SHIFT)
         + ctr_x;
      ty = ((dx * sin_q + dy * cos_q + hlcr_pkg::ROUND_HALF) >>> hlcr_pkg::ROUND_SHIFT)
         + ctr_y;
      c.grid_x = clamp_coord(gx);
      c.grid_y = clamp_coord(gy);
      c.turned_x = clamp_coord(tx);
      c.turned_y = clamp_coord(ty);
      return c;
   endfunction

   task automatic check_field(input string name, input hlcr_pkg::coord_type want,
                              input hlcr_pkg::coord_type got);
      if (want !== got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      lens_center_type want;
      if (reset) begin
         centers_due.delete();
         org_x = 0;
         org_y = 0;
         pitch = 0;
         rpitch = 0;
         ctr_x = 0;
         ctr_y = 0;
         cos_q = hlcr_pkg::COS_RESET;
         sin_q = 0;
      end else begin
         if (rsp_strobe) begin
            if (centers_due.size() == 0) begin
               $error("unexpected result: no lens index pending");
               mismatch_count++;
            end else begin
               want = centers_due.pop_front();
               check_field("grid_x", want.grid_x, rsp_grid_x);
               check_field("grid_y", want.grid_y, rsp_grid_y);
               check_field("turned_x", want.turned_x, rsp_turned_x);
               check_field("turned_y", want.turned_y, rsp_turned_y);
               centers_checked++;
            end
         end
         if (start && !busy) begin
            centers_due.push_back(place_lens(req_lens_row, req_lens_col));
         end
         if (csr_we) begin
            case (csr_index)
               hlcr_pkg::REG_ORIGIN_X:   org_x = longint'(signed'(csr_wdata));
               hlcr_pkg::REG_ORIGIN_Y:   org_y = longint'(signed'(csr_wdata));
               hlcr_pkg::REG_LENS_PITCH:
                  pitch = longint'(csr_wdata[hlcr_pkg::PITCH_W-1:0]);
               hlcr_pkg::REG_ROW_PITCH:
                  rpitch = longint'(csr_wdata[hlcr_pkg::PITCH_W-1:0]);
               hlcr_pkg::REG_CENTER_X:   ctr_x = longint'(signed'(csr_wdata));
               hlcr_pkg::REG_CENTER_Y:   ctr_y = longint'(signed'(csr_wdata));
               hlcr_pkg::REG_COS_ANGLE:
                  cos_q = longint'(signed'(csr_wdata[hlcr_pkg::TRIG_W-1:0]));
               hlcr_pkg::REG_SIN_ANGLE:
                  sin_q = longint'(signed'(csr_wdata[hlcr_pkg::TRIG_W-1:0]));
               default: ;
            endcase
         end
      end
      lenses_pending <= centers_due.size();
   end

endmodule

>>> verif/hex_lens_center_rotate_test.sv
`timescale 1ns / 1ps

module hex_lens_center_rotate_test;

   localparam int PIPE_DEPTH = 6;
   localparam int STALL_LIMIT = 2000;
   localparam int RANDOM_PHASES = 12;
   localparam int LENSES_PER_PHASE = 50;
   localparam logic [hlcr_pkg::INDEX_W-1:0] IDX_MAX = '1;

   logic                                clock;
   logic                                reset;
   logic                                start;
   logic                                busy;
   logic [hlcr_pkg::INDEX_W-1:0]        req_lens_row;
   logic [hlcr_pkg::INDEX_W-1:0]        req_lens_col;
   logic                                rsp_strobe;
   logic signed [hlcr_pkg::COORD_W-1:0] rsp_grid_x;
   logic signed [hlcr_pkg::COORD_W-1:0] rsp_grid_y;
   logic signed [hlcr_pkg::COORD_W-1:0] rsp_turned_x;
   logic signed [hlcr_pkg::COORD_W-1:0] rsp_turned_y;
   logic                                csr_we;
   logic [hlcr_pkg::CSR_IDX_W-1:0]      csr_index;
   logic [hlcr_pkg::COORD_W-1:0]        csr_wdata;

   int mismatch_count;
   int lenses_pending;
   int centers_checked;
   int lenses_sent = 0;
   int settings_applied = 0;
   int stall_cycles = 0;

   hex_lens_center_rotate dut (.*);

   hlcr_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog: cycles with no transaction on any port
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || csr_we) begin
         stall_cycles <= 0;
      end else if (stall_cycles == STALL_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   function automatic int rand_coord(input int bits);
      return int'($urandom) >>> (32 - bits);
   endfunction

   function automatic logic [hlcr_pkg::INDEX_W-1:0] rand_index();
      case ($urandom_range(0, 19))
         0: return '0;
         1: return IDX_MAX;
         2: return hlcr_pkg::INDEX_W'(1);
         default: return hlcr_pkg::INDEX_W'($urandom_range(0, IDX_MAX));
      endcase
   endfunction

   task automatic send_lens(input logic [hlcr_pkg::INDEX_W-1:0] row,
                            input logic [hlcr_pkg::INDEX_W-1:0] col,
                            input int idle_pct);
      while ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         req_lens_row <= hlcr_pkg::INDEX_W'($urandom);
         req_lens_col <= hlcr_pkg::INDEX_W'($urandom);
         @(posedge clock);
      end
      start <= 1'b1;
      req_lens_row <= row;
      req_lens_col <= col;
      @(posedge clock);
      while (busy) @(posedge clock);
      lenses_sent++;
   endtask

   // wait until every pending transaction has come back and the pipe is empty
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (lenses_pending != 0) @(posedge clock);
      repeat (PIPE_DEPTH + 2) @(posedge clock);
   endtask

   task automatic write_reg(input logic [hlcr_pkg::CSR_IDX_W-1:0] idx, input int value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[hlcr_pkg::COORD_W-1:0];
      @(posedge clock);
   endtask

   task automatic apply_settings(input int ox, input int oy, input int lp, input int rp,
                                 input int cx, input int cy, input int cs, input int sn);
      drain();
      write_reg(hlcr_pkg::REG_ORIGIN_X, ox);
      write_reg(hlcr_pkg::REG_ORIGIN_Y, oy);
      write_reg(hlcr_pkg::REG_LENS_PITCH, lp);
      write_reg(hlcr_pkg::REG_ROW_PITCH, rp);
      write_reg(hlcr_pkg::REG_CENTER_X, cx);
      write_reg(hlcr_pkg::REG_CENTER_Y, cy);
      write_reg(hlcr_pkg::REG_COS_ANGLE, cs);
      write_reg(hlcr_pkg::REG_SIN_ANGLE, sn);
      csr_we <= 1'b0;
      settings_applied++;
   endtask

   task automatic pick_settings(input int mode);
      real ang;
      int lp, rp, cs, sn;
      case (mode)
         0: begin
            // plausible optics: pitch*sin60 row spacing, true rotation
            lp = ($urandom_range(0, 3) == 0) ? $urandom_range(1024, 16384)
                                             : $urandom_range(64, 2048);
            rp = $rtoi(lp * 0.8660254);
            ang = $urandom_range(0, 35999) * 3.14159265358979 / 18000.0;
            cs = $rtoi($cos(ang) * 16384.0);
            sn = $rtoi($sin(ang) * 16384.0);
            apply_settings(rand_coord(18), rand_coord(18), lp, rp,
                           rand_coord(20), rand_coord(20), cs, sn);
         end
         1: begin
            if ($urandom_range(0, 1)) begin
               cs = rand_coord(16);
               sn = rand_coord(16);
            end else begin
               cs = int'($urandom_range(0, 32768)) - 16384;
               sn = int'($urandom_range(0, 32768)) - 16384;
            end
            apply_settings(rand_coord(24), rand_coord(24), $urandom_range(0, 65535),
                           $urandom_range(0, 65535), rand_coord(24), rand_coord(24), cs, sn);
         end
         default: begin
            apply_settings($urandom_range(0, 1) ? 8388607 : -8388608,
                           $urandom_range(0, 1) ? 8388607 : -8388608,
                           $urandom_range(0, 1) ? 65535 : 0,
                           $urandom_range(0, 1) ? 65535 : 0,
                           $urandom_range(0, 1) ? 8388607 : -8388608,
                           $urandom_range(0, 1) ? 8388607 : -8388608,
                           $urandom_range(0, 1) ? 16384 : -16384,
                           $urandom_range(0, 1) ? 16384 : -16384);
         end
      endcase
   endtask

   initial begin
      int idle_pct;
      start = 1'b0;
      req_lens_row = '0;
      req_lens_col = '0;
      csr_we = 1'b0;
      csr_index = hlcr_pkg::REG_ORIGIN_X;
      csr_wdata = '0;
      reset = 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset values: zero pitch, identity rotation
      send_lens(0, 0, 0);
      send_lens(1, IDX_MAX, 0);
      send_lens(IDX_MAX, 0, 0);
      send_lens(IDX_MAX, IDX_MAX, 0);

      // origin and pitches at the top of their range, identity rotation: positive saturation
      apply_settings(8388607, 8388607, 65535, 65535, 0, 0, 16384, 0);
      send_lens(0, 0, 0);
      send_lens(IDX_MAX, IDX_MAX, 0);
      send_lens(0, IDX_MAX, 0);

      // origin and pitches at the bottom, far centers, cos -1.0 and sin +1.0: saturation at both ends
      apply_settings(-8388608, -8388608, 0, 0, 8388607, -8388608, -16384, 16384);
      send_lens(0, 0, 0);
      send_lens(IDX_MAX, IDX_MAX, 0);
      send_lens(1, 1, 0);

      // quarter turn about the middle of a 640x480 image
      apply_settings(0, 0, 5120, 4434, 320 * 256, 240 * 256, 0, 16384);
      send_lens(0, 0, 0);
      send_lens(1, 0, 0);
      send_lens(2, 5, 0);
      send_lens(513, 700, 0);

      // trig outside +-1.0, odd pitch so the half pitch truncates
      apply_settings(-1000, 3000, 257, 223, 0, 0, -32768, 32767);
      send_lens(IDX_MAX, IDX_MAX, 0);
      send_lens(0, 0, 0);
      send_lens(1, 1, 0);

      // smallest nonzero trig: products land exactly on one half
      apply_settings(6400, 256 - 8192, 0, 0, 0, 0, 1, -1);
      send_lens(0, 0, 0);
      send_lens(2, 3, 0);

      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         pick_settings(ph % 3);
         idle_pct = (ph < RANDOM_PHASES / 3) ? 26 : (ph < 2 * RANDOM_PHASES / 3) ? 82 : 0;
         for (int n = 0; n < LENSES_PER_PHASE; n++) begin
            send_lens(rand_index(), rand_index(), idle_pct);
         end
      end

      drain();
      $display("Sent %0d lens indices across %0d register settings (directed and random).",
               lenses_sent, settings_applied);
      $display("Checked %0d grid/turned center transactions, %0d mismatches.",
               centers_checked, mismatch_count);
      if (mismatch_count == 0 && lenses_pending == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
